[hdl/tws_pkg.sv]
package tws_pkg;

    localparam int MAX_ITEMS = 32;
    localparam int BUF_DEPTH = 2 * MAX_ITEMS + 1;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int ITEMS_W   = $clog2(MAX_ITEMS + 1);
    localparam int DATA_W    = 32;
    localparam int CNT_W     = 10;

    localparam logic [ADDR_W-1:0]  CENTRE    = ADDR_W'(MAX_ITEMS);
    localparam logic [ITEMS_W-1:0] ITEMS_MAX = ITEMS_W'(MAX_ITEMS);
    localparam logic [CNT_W-1:0]   COUNT_MAX = '1;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic              load;
        logic [DATA_W-1:0] value;
        logic              last;
        logic [CNT_W-1:0]  count;
    } out_load_t;

endpackage

[hdl/tws_if.sv]
interface tws_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [tws_pkg::DATA_W-1:0]      value;
    logic                                   last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface tws_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [tws_pkg::DATA_W-1:0]      sorted_value;
    logic                                   last_res;
    logic [tws_pkg::CNT_W-1:0]              assignment_count;

    modport source (output valid, output sorted_value, output last_res,
                    output assignment_count, input ready);
    modport sink   (input valid, input sorted_value, input last_res,
                    input assignment_count, output ready);
endinterface

[hdl/tws_ram.sv]
module tws_ram (
    input  logic                          clk,
    input  tws_pkg::ram_req_t             req,
    output logic [tws_pkg::DATA_W-1:0]    rdata
);

    logic [tws_pkg::DATA_W-1:0] mem [tws_pkg::BUF_DEPTH];
    logic [tws_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/tws_out.sv]
module tws_out (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tws_pkg::out_load_t   ld,
    output logic                 free,
    tws_out_if.source            out_ch
);

    logic                          valid_reg;
    logic [tws_pkg::DATA_W-1:0]    value_reg;
    logic                          last_reg;
    logic [tws_pkg::CNT_W-1:0]     count_reg;

    assign free = !valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ld.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.load)
        begin
            value_reg <= ld.value;
            last_reg  <= ld.last;
            count_reg <= ld.count;
        end
    end

    assign out_ch.valid            = valid_reg;
    assign out_ch.sorted_value     = $signed(value_reg);
    assign out_ch.last_res         = last_reg;
    assign out_ch.assignment_count = count_reg;

endmodule

[hdl/tws_ctrl.sv]
module tws_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic signed [tws_pkg::DATA_W-1:0] in_value,
    input  logic                              in_last,
    output logic                              in_ready,
    input  logic [tws_pkg::DATA_W-1:0]        rdata,
    output tws_pkg::ram_req_t                 ram_req,
    input  logic                              out_free,
    output tws_pkg::out_load_t                out_ld
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_LO_CMP,
        ST_HI_CMP,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PLACE,
        ST_FINISH,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    state_t                               state_reg, state_next;
    logic signed [tws_pkg::DATA_W-1:0]    key_reg, key_next;
    logic                                 last_reg, last_next;
    logic [tws_pkg::ADDR_W-1:0]           low_reg, low_next;
    logic [tws_pkg::ADDR_W-1:0]           high_reg, high_next;
    logic [tws_pkg::ITEMS_W-1:0]          items_reg, items_next;
    logic [tws_pkg::CNT_W-1:0]            cnt_reg, cnt_next;
    logic [tws_pkg::ADDR_W-1:0]           j_reg, j_next;
    logic [tws_pkg::ADDR_W-1:0]           k_reg, k_next;
    logic                                 left_reg, left_next;
    logic [tws_pkg::ADDR_W-1:0]           emit_reg, emit_next;
    logic signed [tws_pkg::DATA_W-1:0]    rd_s;
    logic [tws_pkg::CNT_W-1:0]            cnt_inc;
    logic                                 emit_last;

    assign rd_s      = $signed(rdata);
    assign cnt_inc   = (cnt_reg == tws_pkg::COUNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
    assign emit_last = (emit_reg == high_reg - 1'b1);
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        last_next  = last_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        items_next = items_reg;
        cnt_next   = cnt_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        left_next  = left_reg;
        emit_next  = emit_reg;
        ram_req    = '0;
        out_ld     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    key_next   = in_value;
                    last_next  = in_last;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (items_reg == tws_pkg::ITEMS_MAX)
                begin
                    state_next = ST_FINISH;
                end
                else if (items_reg == '0)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = tws_pkg::CENTRE;
                    ram_req.wdata = key_reg;
                    items_next    = tws_pkg::ITEMS_W'(1);
                    state_next    = ST_FINISH;
                end
                else
                begin
                    items_next    = items_reg + 1'b1;
                    ram_req.raddr = low_reg + 1'b1;
                    state_next    = ST_LO_CMP;
                end
            end
            ST_LO_CMP:
            begin
                if (key_reg < rd_s)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = low_reg;
                    ram_req.wdata = key_reg;
                    low_next      = low_reg - 1'b1;
                    cnt_next      = cnt_inc;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    ram_req.raddr = high_reg - 1'b1;
                    state_next    = ST_HI_CMP;
                end
            end
            ST_HI_CMP:
            begin
                if (key_reg > rd_s)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = high_reg;
                    ram_req.wdata = key_reg;
                    high_next     = high_reg + 1'b1;
                    cnt_next      = cnt_inc;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    j_next     = high_reg - 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                ram_req.raddr = j_reg;
                state_next    = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                if ((j_reg > low_reg) && (key_reg < rd_s))
                begin
                    j_next     = j_reg - 1'b1;
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    if ((j_reg - low_reg) < (high_reg - j_reg - 1'b1))
                    begin
                        left_next = 1'b1;
                        k_next    = low_reg;
                    end
                    else
                    begin
                        left_next = 1'b0;
                        j_next    = j_reg + 1'b1;
                        k_next    = high_reg;
                    end
                    state_next = ST_SHIFT_RD;
                end
            end
            ST_SHIFT_RD:
            begin
                if (left_reg ? (k_reg < j_reg) : (k_reg > j_reg))
                begin
                    ram_req.raddr = left_reg ? k_reg + 1'b1 : k_reg - 1'b1;
                    state_next    = ST_SHIFT_WR;
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_SHIFT_WR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = k_reg;
                ram_req.wdata = rdata;
                cnt_next      = cnt_inc;
                k_next        = left_reg ? k_reg + 1'b1 : k_reg - 1'b1;
                state_next    = ST_SHIFT_RD;
            end
            ST_PLACE:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = j_reg;
                ram_req.wdata = key_reg;
                cnt_next      = cnt_inc;
                if (left_reg)
                begin
                    low_next = low_reg - 1'b1;
                end
                else
                begin
                    high_next = high_reg + 1'b1;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (last_reg)
                begin
                    emit_next  = low_reg + 1'b1;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_RD:
            begin
                if (out_free)
                begin
                    ram_req.raddr = emit_reg;
                    state_next    = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD:
            begin
                out_ld.load  = 1'b1;
                out_ld.value = rdata;
                out_ld.last  = emit_last;
                out_ld.count = cnt_reg;
                if (emit_last)
                begin
                    low_next   = tws_pkg::CENTRE - 1'b1;
                    high_next  = tws_pkg::CENTRE + 1'b1;
                    items_next = '0;
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    emit_next  = emit_reg + 1'b1;
                    state_next = ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            key_reg   <= '0;
            last_reg  <= 1'b0;
            low_reg   <= tws_pkg::CENTRE - 1'b1;
            high_reg  <= tws_pkg::CENTRE + 1'b1;
            items_reg <= '0;
            cnt_reg   <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            left_reg  <= 1'b0;
            emit_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
            last_reg  <= last_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            items_reg <= items_next;
            cnt_reg   <= cnt_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            left_reg  <= left_next;
            emit_reg  <= emit_next;
        end
    end

    a_edges_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        low_reg < high_reg)
        else $error("low edge not below high edge");

    a_items_bound: assert property (@(posedge clk) disable iff (!rst_n)
        items_reg <= tws_pkg::ITEMS_MAX)
        else $error("item count above capacity");

    a_run_matches_items: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && items_reg != '0) |->
        (high_reg - low_reg - 1'b1 == tws_pkg::ADDR_W'(items_reg)))
        else $error("occupied run length differs from item count");

    a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> (ram_req.waddr < tws_pkg::ADDR_W'(tws_pkg::BUF_DEPTH)))
        else $error("buffer write outside depth");

endmodule

[hdl/two_way_insertion_sorter.sv]
// Each value goes into a run kept sorted in the buffer RAM: the first at the centre, then at
// the low or high edge, or in the middle after a scan and a shift of the nearer side. A value
// that arrives with the set full is dropped. One item at a time: a new value is taken only
// once the last is placed. On a last item, results are read out in order from the single RAM
// read port, held back while the output stalls. Reset (rst_n, async, active low) empties the
// set and clears all control; buffer RAM contents are not cleared.
module two_way_insertion_sorter (
    input  logic        clk,
    input  logic        rst_n,
    tws_in_if.sink      in_ch,
    tws_out_if.source   out_ch
);

    tws_pkg::ram_req_t             ram_req;
    logic [tws_pkg::DATA_W-1:0]    rdata;
    tws_pkg::out_load_t            out_ld;
    logic                          out_free;

    tws_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (rdata)
    );

    tws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_value (in_ch.value),
        .in_last  (in_ch.last),
        .in_ready (in_ch.ready),
        .rdata    (rdata),
        .ram_req  (ram_req),
        .out_free (out_free),
        .out_ld   (out_ld)
    );

    tws_out u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .ld     (out_ld),
        .free   (out_free),
        .out_ch (out_ch)
    );

endmodule

[verif/tws_sort_checker.sv]
module tws_sort_checker
    import tws_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tws_in_if    in_mon,
    tws_out_if   out_mon,
    output int   mismatches,
    output int   pending,
    output int   results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic [CNT_W-1:0]         count;
    } sorted_entry_t;

    localparam int MID = int'(CENTRE);

    logic signed [DATA_W-1:0] slots [0:BUF_DEPTH-1];
    int                       low_free;
    int                       high_free;
    int                       stored;
    logic [CNT_W-1:0]         writes;
    sorted_entry_t            due_sorted [$];

    function automatic logic [CNT_W-1:0] count_write(input logic [CNT_W-1:0] n);
        return (n == COUNT_MAX) ? n : n + 1'b1;
    endfunction

    task automatic start_set();
        low_free  = MID - 1;
        high_free = MID + 1;
        stored    = 0;
        writes    = '0;
    endtask

    task automatic absorb_value(input logic signed [DATA_W-1:0] key, input logic is_last);
        int            j;
        int            k;
        sorted_entry_t entry;
        if (stored < MAX_ITEMS)
        begin
            if (stored == 0)
            begin
                slots[MID] = key;
                stored     = 1;
            end
            else
            begin
                stored++;
                if (key < slots[low_free + 1])
                begin
                    slots[low_free] = key;
                    low_free--;
                    writes = count_write(writes);
                end
                else if (key > slots[high_free - 1])
                begin
                    slots[high_free] = key;
                    high_free++;
                    writes = count_write(writes);
                end
                else
                begin
                    j = high_free - 1;
                    while (j > low_free && key < slots[j])
                        j--;
                    if ((j - low_free) < (high_free - (j + 1)))
                    begin
                        for (k = low_free; k < j; k++)
                        begin
                            slots[k] = slots[k + 1];
                            writes   = count_write(writes);
                        end
                        low_free--;
                    end
                    else
                    begin
                        j++;
                        for (k = high_free; k > j; k--)
                        begin
                            slots[k] = slots[k - 1];
                            writes   = count_write(writes);
                        end
                        high_free++;
                    end
                    slots[j] = key;
                    writes   = count_write(writes);
                end
            end
        end
        if (is_last)
        begin
            for (k = 0; k < stored; k++)
            begin
                entry.value = slots[low_free + 1 + k];
                entry.last  = (k + 1 == stored);
                entry.count = writes;
                due_sorted.push_back(entry);
            end
            start_set();
        end
    endtask

    initial
    begin
        start_set();
        mismatches   = 0;
        pending      = 0;
        results_seen = 0;
    end

    always @(posedge clk)
    begin
        sorted_entry_t want;
        if (rst_n)
        begin
            if (in_mon.valid && in_mon.ready)
                absorb_value(in_mon.value, in_mon.last);
            if (out_mon.valid && out_mon.ready)
            begin
                results_seen++;
                if (due_sorted.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result value=%0d last=%0b count=%0d",
                                 $realtime, out_mon.sorted_value, out_mon.last_res,
                                 out_mon.assignment_count);
                end
                else
                begin
                    want = due_sorted.pop_front();
                    if (out_mon.sorted_value !== want.value || out_mon.last_res !== want.last
                        || out_mon.assignment_count !== want.count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: result mismatch: expected value=%0d last=%0b ",
                                      "count=%0d, got value=%0d last=%0b count=%0d"},
                                     $realtime, want.value, want.last, want.count,
                                     out_mon.sorted_value, out_mon.last_res,
                                     out_mon.assignment_count);
                    end
                end
            end
            pending = due_sorted.size();
        end
    end

endmodule

[verif/two_way_insertion_sorter_tb.sv]
module two_way_insertion_sorter_tb;
    import tws_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 500;
    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    logic clk;
    logic rst_n;
    logic calm;
    int   cycles;
    int   inputs_sent;
    int   sets_sent;
    int   full_sets;
    int   mismatches;
    int   pending;
    int   results_seen;

    tws_in_if  in_if ();
    tws_out_if out_if ();

    two_way_insertion_sorter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .out_ch (out_if)
    );

    tws_sort_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_mon       (in_if),
        .out_mon      (out_if),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    initial
        cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycles, pending);
            $display("two_way_insertion_sorter_tb failed");
            $finish;
        end
    end

    task automatic send_value(input logic signed [DATA_W-1:0] v, input logic l);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.value <= v;
        in_if.last  <= l;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        inputs_sent++;
        if (l)
            sets_sent++;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value(input int flavor);
        logic signed [DATA_W-1:0] v;
        case (flavor)
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 15)) - 8;
            2:
            begin
                case ($urandom_range(0, 6))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = VAL_MIN + 1;
                    3: v = VAL_MAX - 1;
                    4: v = 0;
                    5: v = -1;
                    default: v = 1;
                endcase
            end
            default: v = $signed($urandom_range(0, 1999)) - 1000;
        endcase
        return v;
    endfunction

    task automatic send_list(input logic signed [DATA_W-1:0] vals [$]);
        int i;
        for (i = 0; i < vals.size(); i++)
            send_value(vals[i], i == vals.size() - 1);
    endtask

    initial
    begin
        out_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            int stall;
            stall = calm ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_if.ready <= 1'b1;
            @(posedge clk);
            while (!out_if.valid)
                @(posedge clk);
        end
    end

    initial
    begin
        int  left;
        int  len;
        int  flavor;
        int  i;
        logic signed [DATA_W-1:0] v;

        rst_n        = 1'b0;
        calm         = 1'b0;
        in_if.valid  = 1'b0;
        in_if.value  = '0;
        in_if.last   = 1'b0;
        inputs_sent  = 0;
        sets_sent    = 0;
        full_sets    = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single value, extremes, equal run, descending run, middle shifts both ways, reversed extremes
        send_list('{32'sd0});
        send_list('{VAL_MIN, VAL_MAX, 32'sd0, -32'sd1, 32'sd1});
        send_list('{32'sd5, 32'sd5, 32'sd5, 32'sd5});
        send_list('{32'sd10, 32'sd8, 32'sd6, 32'sd4});
        send_list('{32'sd0, 32'sd100, 32'sd200, 32'sd300, 32'sd50, 32'sd250});
        send_list('{VAL_MAX, VAL_MIN});

        left = RANDOM_ITEMS;
        while (left > 0)
        begin
            calm   = ($urandom_range(0, 3) == 0);
            flavor = $urandom_range(0, 3);
            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(MAX_ITEMS - 2, MAX_ITEMS + 8);
            else
                len = $urandom_range(1, 10);
            if (len > MAX_ITEMS)
                full_sets++;
            for (i = 0; i < len; i++)
            begin
                v = ($urandom_range(0, 5) == 0) ? pick_value($urandom_range(0, 3))
                                                : pick_value(flavor);
                send_value(v, i == len - 1);
            end
            left -= len;
        end
        in_if.valid <= 1'b0;
        calm = 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("sent %0d values in %0d sets (%0d overfilled past %0d), checked %0d results",
                 inputs_sent, sets_sent, full_sets, MAX_ITEMS, results_seen);
        $display("stimulus mixed extremes, duplicates, random words and idle gaps on both sides");
        if (mismatches == 0)
            $display("two_way_insertion_sorter_tb passed");
        else
            $display("two_way_insertion_sorter_tb failed");
        $finish;
    end

endmodule
